// ----- sv/ppcs_pkg.sv -----
package ppcs_pkg;

  localparam int LEN_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] LFSR_SEED_ZERO = 32'h1ACE_B00C;
  localparam logic [31:0] LFSR_RESET     = 32'h1234_5678;

  localparam logic [LEN_W-1:0] TARGET_RESET = 11'd1500;
  localparam logic [LEN_W-1:0] ALIGN_RESET  = 11'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAD_ENABLE   = 2'd0,
    REG_CHAFF_ENABLE = 2'd1,
    REG_TARGET_LEN   = 2'd2,
    REG_ALIGN_LEN    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_CHAFF   = 2'd2
  } byte_kind_e;

  typedef enum logic [1:0] {
    PH_RECEIVE = 2'b01,
    PH_TRAIL   = 2'b10
  } phase_e;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_FILL = 1'b1
  } command_e;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data;
    logic              eop;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              final_byte;
    logic [1:0]        kind;
  } result_t;

endpackage

// ----- sv/ppcs_in_reg.sv -----
module ppcs_in_reg import ppcs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  consume_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  assign in_ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/ppcs_out_reg.sv -----
module ppcs_out_reg import ppcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/ppcs_core.sv -----
module ppcs_core import ppcs_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 1500
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  input  logic                 take_i,
  input  item_t                item_i,
  output logic                 res_valid_o,
  output result_t              res_o
);

  localparam int RawW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CntW = (RawW > LEN_W) ? RawW : LEN_W;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PACKET_BYTES);

  logic             pad_en_q, pad_en_d;
  logic             chaff_en_q, chaff_en_d;
  logic [LEN_W-1:0] target_q, target_d;
  logic [LEN_W-1:0] align_q, align_d;

  logic [CntW-1:0]  rcv_q, rcv_d;
  logic [LEN_W-1:0] aphase_q, aphase_d;
  logic [CntW-1:0]  emit_q, emit_d;
  logic [CntW-1:0]  pad_end_q, pad_end_d;
  phase_e           phase_q, phase_d;
  logic [31:0]      lfsr_q, lfsr_d;

  logic [CntW-1:0]  tgt_ext;
  logic             in_range;
  logic             passed;
  logic [CntW-1:0]  rcv_n;
  logic [LEN_W:0]   aphase_inc;
  logic [LEN_W-1:0] aphase_n;
  logic [CntW-1:0]  emit_n;
  logic [CntW:0]    pe;
  logic             due;
  logic             pad_due;
  logic             chaff_due;
  logic [CntW-1:0]  emit_1;
  logic             due_after;
  logic [31:0]      lfsr_src;
  logic [31:0]      lfsr_next;

  assign tgt_ext = CntW'(target_q);

  // Fibonacci LFSR step; an all-zero state is reseeded first.
  always_comb begin
    lfsr_src  = (lfsr_q == '0) ? LFSR_SEED_ZERO : lfsr_q;
    lfsr_next = {lfsr_src[0] ^ lfsr_src[2] ^ lfsr_src[3] ^ lfsr_src[5], lfsr_src[31:1]};
  end

  always_comb begin
    pad_en_d   = pad_en_q;
    chaff_en_d = chaff_en_q;
    target_d   = target_q;
    align_d    = align_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PAD_ENABLE:   pad_en_d   = cfg_data_i[0];
        REG_CHAFF_ENABLE: chaff_en_d = cfg_data_i[0];
        REG_TARGET_LEN:   target_d   = cfg_data_i;
        REG_ALIGN_LEN:    align_d    = cfg_data_i;
        default:          ;
      endcase
    end
  end

  always_comb begin
    rcv_d       = rcv_q;
    aphase_d    = aphase_q;
    emit_d      = emit_q;
    pad_end_d   = pad_end_q;
    phase_d     = phase_q;
    lfsr_d      = lfsr_q;
    res_valid_o = 1'b0;
    res_o.data       = item_i.data;
    res_o.final_byte = 1'b0;
    res_o.kind       = KIND_PAYLOAD;

    in_range   = rcv_q < MaxCnt;
    passed     = in_range && (!pad_en_q || (rcv_q < tgt_ext));
    rcv_n      = in_range ? rcv_q + 1'b1 : rcv_q;
    aphase_inc = {1'b0, aphase_q} + 1'b1;
    if (!in_range) begin
      aphase_n = aphase_q;
    end else if (aphase_inc >= {1'b0, align_q}) begin
      aphase_n = '0;
    end else begin
      aphase_n = aphase_inc[LEN_W-1:0];
    end
    emit_n = passed ? emit_q + 1'b1 : emit_q;

    // Length after zero padding, with the counts that this byte leaves.
    pe = {1'b0, rcv_n};
    if (pad_en_q) begin
      if (align_q != '0 && aphase_n != '0 && aphase_n < align_q) begin
        pe = {1'b0, rcv_n} + (CntW + 1)'(align_q - aphase_n);
      end
      if (pe > {1'b0, tgt_ext}) begin
        pe = {1'b0, tgt_ext};
      end
      if (pe < {1'b0, emit_n}) begin
        pe = {1'b0, emit_n};
      end
    end else begin
      pe = {1'b0, emit_n};
    end
    due = ({1'b0, emit_n} < pe) || (chaff_en_q && (emit_n < tgt_ext));

    pad_due   = emit_q < pad_end_q;
    chaff_due = chaff_en_q && (emit_q < tgt_ext);
    emit_1    = emit_q + 1'b1;
    due_after = (emit_1 < pad_end_q) || (chaff_en_q && (emit_1 < tgt_ext));

    if (take_i) begin
      if (item_i.command == CMD_DATA && phase_q == PH_RECEIVE) begin
        res_valid_o = passed;
        if (item_i.eop) begin
          if (due) begin
            rcv_d     = rcv_n;
            aphase_d  = aphase_n;
            emit_d    = emit_n;
            pad_end_d = pe[CntW-1:0];
            phase_d   = PH_TRAIL;
          end else begin
            rcv_d     = '0;
            aphase_d  = '0;
            emit_d    = '0;
            pad_end_d = '0;
            res_o.final_byte = 1'b1;
          end
        end else begin
          rcv_d    = rcv_n;
          aphase_d = aphase_n;
          emit_d   = emit_n;
        end
      end else if (item_i.command == CMD_FILL && phase_q == PH_TRAIL) begin
        if (!pad_due && !chaff_due) begin
          rcv_d     = '0;
          aphase_d  = '0;
          emit_d    = '0;
          pad_end_d = '0;
          phase_d   = PH_RECEIVE;
        end else begin
          res_valid_o = 1'b1;
          if (pad_due) begin
            res_o.data = '0;
            res_o.kind = KIND_PAD;
          end else begin
            res_o.data = lfsr_next[BYTE_W-1:0];
            res_o.kind = KIND_CHAFF;
            lfsr_d     = lfsr_next;
          end
          res_o.final_byte = !due_after;
          if (due_after) begin
            emit_d = emit_1;
          end else begin
            rcv_d     = '0;
            aphase_d  = '0;
            emit_d    = '0;
            pad_end_d = '0;
            phase_d   = PH_RECEIVE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_en_q   <= 1'b1;
      chaff_en_q <= 1'b1;
      target_q   <= TARGET_RESET;
      align_q    <= ALIGN_RESET;
      rcv_q      <= '0;
      aphase_q   <= '0;
      emit_q     <= '0;
      pad_end_q  <= '0;
      phase_q    <= PH_RECEIVE;
      lfsr_q     <= LFSR_RESET;
    end else begin
      pad_en_q   <= pad_en_d;
      chaff_en_q <= chaff_en_d;
      target_q   <= target_d;
      align_q    <= align_d;
      rcv_q      <= rcv_d;
      aphase_q   <= aphase_d;
      emit_q     <= emit_d;
      pad_end_q  <= pad_end_d;
      phase_q    <= phase_d;
      lfsr_q     <= lfsr_d;
    end
  end

endmodule

// ----- sv/packet_pad_and_chaff_shaper.sv -----
// Packet length shaper: passes a packet byte by byte, truncates it at the target
// length and pads it with zero bytes to the alignment (both when padding is on),
// then with LFSR chaff up to the target length when chaff is on.
// The input channel carries one transaction per data byte (command 0) or per
// fill tick (command 1); after the last byte, each fill tick draws one trailing
// byte. The output channel carries the shaped bytes with their kind, and
// final_byte marks the last byte of the shaped packet. Dropped bytes and idle
// fill ticks produce no output transaction.
// Throughput is one transaction per cycle while the receiver does not stall. An
// accepted transaction is held in the input register, then processed into the
// result register, from which it is offered on the output.
// When the receiver stalls, the result register holds its byte and the input
// register takes a transaction only while empty, then in_ready_o stays low.
// Reset clears both registers, restores the configuration defaults (padding and
// chaff on, target 1500, alignment 16) and loads the LFSR with its start value.
// Configuration writes take effect at the next clock edge; the user must make
// them only while no transaction is in flight, as the block does not enforce it.
module packet_pad_and_chaff_shaper import ppcs_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 1500
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [BYTE_W-1:0]    data_in_i,
  input  logic                 end_of_packet_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    data_out_o,
  output logic                 final_byte_o,
  output logic [1:0]           byte_kind_o
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    space;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.command = command_i;
  assign in_item.data    = data_in_i;
  assign in_item.eop     = end_of_packet_i;

  assign take = held_valid && space;

  ppcs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .consume_i  (space),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  ppcs_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ppcs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign data_out_o   = out_res.data;
  assign final_byte_o = out_res.final_byte;
  assign byte_kind_o  = out_res.kind;

endmodule
